// ===== rtl/core/sorted_list_table_assert.svh =====
// Assertion macros used by the RTL of the sorted list table.
`ifndef SORTED_LIST_TABLE_ASSERT_SVH
`define SORTED_LIST_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SLT_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define SLT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/slt_pkg.sv =====
package slt_pkg;

	// Default table depth and the fixed width of a stored value.
	localparam int DEPTH_DEF = 16;
	localparam int VALUE_W   = 32;

	// Command codes carried in the input word's tuser.
	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_QUERY  = 2'd3
	} cmd_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	// One cell's contents as seen by its neighbors.
	typedef struct packed {
		logic                      valid;
		logic signed [VALUE_W-1:0] data;
	} link_t;

	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		logic                      cmp_en;
		logic                      upd_en;
		logic                      apply;
		cmd_t                      cmd;
		logic signed [VALUE_W-1:0] value;
	} ctrl_t;

endpackage

// ===== rtl/core/slt_cell.sv =====
module slt_cell
	import slt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  ctrl_t ctrl,
	input  link_t from_prev,
	input  link_t from_next,
	input  logic  carry_in,
	output logic  carry_out,
	output link_t mine
);

	logic                      valid_q;
	logic signed [VALUE_W-1:0] data_q;
	logic                      lt_s1;
	logic                      eq_s1;
	logic                      hit;

	// Compare phase: register how the stored entry relates to the command value.
	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			lt_s1 <= (data_q < ctrl.value);
			eq_s1 <= (data_q == ctrl.value);
		end
	end

	// Local match for the command; the carry tells later cells that an earlier one matched.
	always_comb begin
		case (ctrl.cmd)
			CMD_INSERT: hit = !valid_q || !lt_s1;
			CMD_APPEND: hit = !valid_q;
			CMD_DELETE: hit = valid_q && eq_s1;
			CMD_QUERY:  hit = valid_q && eq_s1;
			default:    hit = 1'b0;
		endcase
	end

	assign carry_out = carry_in | hit;

	// Update phase: shift toward the tail on insert, toward the head on delete.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.upd_en && ctrl.apply) begin
			if (ctrl.cmd == CMD_DELETE) begin
				if (carry_in || hit) begin
					valid_q <= from_next.valid;
				end
			end else if (carry_in) begin
				valid_q <= from_prev.valid;
			end else if (hit) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.upd_en && ctrl.apply) begin
			if (ctrl.cmd == CMD_DELETE) begin
				if (carry_in || hit) begin
					data_q <= from_next.data;
				end
			end else if (carry_in) begin
				data_q <= from_prev.data;
			end else if (hit) begin
				data_q <= ctrl.value;
			end
		end
	end

	assign mine.valid = valid_q;
	assign mine.data  = data_q;

endmodule

// ===== rtl/core/sorted_list_table.sv =====
// Sorted list table: a chain of DEPTH cells, each holding one entry and a valid bit.
// Each word passes through a compare phase and then an update phase before its result is registered.
// A new word is accepted only in the idle state, once the previous word's update phase is done.
// The update phase waits while an earlier result has not been taken.
// Reset (arst_n low, asynchronous) empties the table and clears the result valid flag.
// Entry data is not reset; of the table contents only the cell valid bits and the count are.
module sorted_list_table
	import slt_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int CNT_W = $clog2(DEPTH + 1),
	localparam int OUT_W = ((2 + CNT_W + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [VALUE_W-1:0] s_tdata,  // [31:0] value
	input  logic [1:0]         s_tuser,  // [1:0] command
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata   // [0] found, [1] dropped, [CNT_W+1:2] entry_count
);

	`include "sorted_list_table_assert.svh"

	state_t                    state_q;
	state_t                    state_next;
	cmd_t                      cmd_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          count_out_q;
	logic                      found_q;
	logic                      dropped_q;
	logic                      out_valid_q;
	logic                      full;
	logic                      upd_go;
	logic                      any_hit;
	logic                      new_found;
	logic                      new_dropped;
	logic [CNT_W-1:0]          new_count;
	ctrl_t                     ctrl;
	link_t                     cell_link [DEPTH];
	logic [DEPTH:0]            carry;
	logic [DEPTH-1:0]          valid_vec;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign s_tready = (state_q == ST_IDLE);
	assign upd_go   = (state_q == ST_UPD) && (!out_valid_q || m_tready);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid) state_next = ST_CMP;
			ST_CMP:  state_next = ST_UPD;
			ST_UPD:  if (upd_go) state_next = ST_IDLE;
			default: state_next = ST_IDLE;
		endcase
	end

	// Capture the accepted word.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q   <= cmd_t'(s_tuser);
			value_q <= signed'(s_tdata);
		end
	end

	// Control broadcast to the cells.
	always_comb begin
		ctrl.cmp_en = (state_q == ST_CMP);
		ctrl.upd_en = upd_go;
		ctrl.apply  = ((cmd_q == CMD_INSERT || cmd_q == CMD_APPEND) && !full)
			|| (cmd_q == CMD_DELETE);
		ctrl.cmd    = cmd_q;
		ctrl.value  = value_q;
	end

	// The cell chain.
	assign carry[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		link_t prev_link;
		link_t next_link;

		if (i == 0) begin : g_head
			assign prev_link = '{valid: 1'b0, data: '0};
		end else begin : g_mid
			assign prev_link = cell_link[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_link = '{valid: 1'b0, data: '0};
		end else begin : g_body
			assign next_link = cell_link[i+1];
		end

		slt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.from_prev (prev_link),
			.from_next (next_link),
			.carry_in  (carry[i]),
			.carry_out (carry[i+1]),
			.mine      (cell_link[i])
		);

		assign valid_vec[i] = cell_link[i].valid;
	end

	assign any_hit = carry[DEPTH];

	// Result of the command and the count that follows it.
	always_comb begin
		new_found   = 1'b0;
		new_dropped = 1'b0;
		new_count   = count_q;
		case (cmd_q)
			CMD_INSERT, CMD_APPEND: begin
				if (full) begin
					new_dropped = 1'b1;
				end else begin
					new_count = count_q + CNT_W'(1);
				end
			end
			CMD_DELETE: begin
				new_found = any_hit;
				if (any_hit) begin
					new_count = count_q - CNT_W'(1);
				end
			end
			CMD_QUERY: new_found = any_hit;
			default: new_found = 1'b0;
		endcase
	end

	// Count register and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (upd_go) begin
				count_q     <= new_count;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			found_q     <= new_found;
			dropped_q   <= new_dropped;
			count_out_q <= new_count;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({count_out_q, dropped_q, found_q});

	// Checks on the chain and the sequencer.
	`SLT_ASSERT_IMPLY(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH),
		"stored count exceeds the table depth")
	`SLT_ASSERT_IMPLY(a_valid_match, state_q == ST_IDLE,
		$countones(valid_vec) == int'(count_q),
		"cell valid bits disagree with the stored count")
	`SLT_ASSERT_IMPLY(a_flags_excl, out_valid_q, !(found_q && dropped_q),
		"result has both found and dropped set")
	`SLT_ASSERT_IMPLY(a_drop_full, out_valid_q && dropped_q, count_out_q == CNT_W'(DEPTH),
		"dropped result with a table that is not full")
	`SLT_ASSERT_NEXT(a_accept_cmp, s_tvalid && s_tready, state_q == ST_CMP,
		"accepted word did not start a compare phase")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import slt_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int OUT_W = ((2 + CNT_W + 7) / 8) * 8;

	// One command word as it waits in the driver queue, with its idle gap.
	typedef struct {
		cmd_t                      cmd;
		logic signed [VALUE_W-1:0] value;
		int unsigned               gap;
	} list_op_t;

	// Result word fields in the same order as they sit in m_tdata.
	typedef struct packed {
		logic [CNT_W-1:0] entry_count;
		logic             dropped;
		logic             found;
	} list_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [VALUE_W-1:0] s_tdata = '0;  // [31:0] value
	logic [1:0]         s_tuser = CMD_INSERT;  // [1:0] command
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [OUT_W-1:0]   m_tdata;  // [0] found, [1] dropped, [CNT_W+1:2] entry_count

	// Mirror of the table contents, updated as each command word is accepted.
	logic signed [VALUE_W-1:0] list_vals [DEPTH];
	int                        list_len = 0;

	list_op_t     pending_ops [$];
	list_result_t expected_results [$];
	int           mismatch_count = 0;
	bit           quiet_stretch = 1'b0;

	sorted_list_table #(.DEPTH(DEPTH)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// Applies one command to the mirrored table and returns the result it should give.
	function automatic list_result_t apply_command(input cmd_t cmd,
			input logic signed [VALUE_W-1:0] value);
		list_result_t res;
		int pos;
		res = '0;
		pos = list_len;
		case (cmd)
			CMD_INSERT, CMD_APPEND: begin
				if (list_len >= DEPTH) begin
					res.dropped = 1'b1;
				end else begin
					// A sorted insert lands before the first entry that is not less.
					if (cmd == CMD_INSERT) begin
						for (int i = list_len - 1; i >= 0; i--)
							if (!(list_vals[i] < value))
								pos = i;
					end
					for (int i = list_len; i > pos; i--)
						list_vals[i] = list_vals[i - 1];
					list_vals[pos] = value;
					list_len++;
				end
			end
			CMD_DELETE: begin
				for (int i = list_len - 1; i >= 0; i--)
					if (list_vals[i] == value)
						pos = i;
				if (pos < list_len) begin
					for (int i = pos; i + 1 < list_len; i++)
						list_vals[i] = list_vals[i + 1];
					list_len--;
					res.found = 1'b1;
				end
			end
			default: begin
				for (int i = 0; i < list_len; i++)
					if (list_vals[i] == value)
						res.found = 1'b1;
			end
		endcase
		res.entry_count = CNT_W'(list_len);
		return res;
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// Values come mostly from a small pool so that deletes and queries often hit.
	function automatic logic signed [VALUE_W-1:0] pick_value();
		int idx;
		if ($urandom_range(0, 99) >= 55)
			return $urandom;
		idx = $urandom_range(0, 8);
		if (idx == 7)
			return {1'b1, {(VALUE_W-1){1'b0}}};
		else if (idx == 8)
			return {1'b0, {(VALUE_W-1){1'b1}}};
		else
			return VALUE_W'(idx - 3);
	endfunction

	task automatic add_op(input cmd_t cmd, input logic signed [VALUE_W-1:0] value);
		list_op_t op;
		op.cmd = cmd;
		op.value = value;
		op.gap = quiet_stretch ? 0 : pick_gap();
		pending_ops.push_back(op);
	endtask

	// Driver: presents queued words, holding each until it is taken.
	always @(posedge clk) begin
		list_op_t op;
		int unsigned gap_left;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(apply_command(cmd_t'(s_tuser), s_tdata));
			if (!(s_tvalid && !s_tready)) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					op = pending_ops.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= op.value;
					s_tuser <= op.cmd;
					gap_left = op.gap;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result word and stalls the output at random.
	always @(posedge clk) begin
		list_result_t got;
		list_result_t want;
		int unsigned stall_left;
		int unsigned stall_pct;
		int unsigned cycle_cnt;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
			stall_pct = 0;
			cycle_cnt = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[2+CNT_W-1:0];
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result word %h", $time, m_tdata);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					if (got.found !== want.found) begin
						$display("%0t: found expected %b actual %b",
							$time, want.found, got.found);
						mismatch_count++;
					end
					if (got.dropped !== want.dropped) begin
						$display("%0t: dropped expected %b actual %b",
							$time, want.dropped, got.dropped);
						mismatch_count++;
					end
					if (got.entry_count !== want.entry_count) begin
						$display("%0t: entry_count expected %0d actual %0d",
							$time, want.entry_count, got.entry_count);
						mismatch_count++;
					end
				end
			end
			// Change the stall rate now and then, including stretches with none.
			cycle_cnt++;
			if (cycle_cnt % 256 == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 10;
					2: stall_pct = 30;
					default: stall_pct = 60;
				endcase
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 99) < stall_pct)
					stall_left = pick_gap();
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int unsigned mode;
		int unsigned r;
		cmd_t cmd;
		// Empty table, extremes, duplicates and an unsorted tail.
		add_op(CMD_QUERY, 32'sd0);
		add_op(CMD_DELETE, 32'sd5);
		add_op(CMD_INSERT, 32'h7FFF_FFFF);
		add_op(CMD_INSERT, 32'h8000_0000);
		add_op(CMD_INSERT, 32'sd0);
		add_op(CMD_INSERT, 32'sd0);
		add_op(CMD_APPEND, -32'sd1);
		add_op(CMD_INSERT, -32'sd5);
		add_op(CMD_QUERY, 32'h7FFF_FFFF);
		add_op(CMD_QUERY, 32'sd1);
		add_op(CMD_DELETE, 32'sd0);
		add_op(CMD_DELETE, 32'sd7);
		// Fill the table, then try to add past full.
		for (int i = 0; i < 11; i++)
			add_op((i % 2) ? CMD_APPEND : CMD_INSERT,
				(i % 2) ? (32'hAAAA_AAAA ^ i) : (32'h5555_5555 ^ i));
		add_op(CMD_INSERT, 32'sd1);
		add_op(CMD_APPEND, 32'sd2);
		add_op(CMD_DELETE, 32'h8000_0000);

		// Random part in blocks that lean toward growing, shrinking or neither.
		for (int blk = 0; blk < 25; blk++) begin
			mode = $urandom_range(0, 2);
			quiet_stretch = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < 40; i++) begin
				r = $urandom_range(0, 99);
				if (mode == 0)
					cmd = (r < 45) ? CMD_INSERT : (r < 70) ? CMD_APPEND :
						(r < 85) ? CMD_DELETE : CMD_QUERY;
				else if (mode == 1)
					cmd = (r < 15) ? CMD_INSERT : (r < 25) ? CMD_APPEND :
						(r < 80) ? CMD_DELETE : CMD_QUERY;
				else
					cmd = cmd_t'(r % 4);
				add_op(cmd, pick_value());
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#6_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
